// ===== hw/rtl/multi_stack_shared_store_assert.svh =====
// assertion macros shared by the multi-stack store rtl
// included by the controller and datapath files; no other dependencies
`ifndef MULTI_STACK_SHARED_STORE_ASSERT_SVH
`define MULTI_STACK_SHARED_STORE_ASSERT_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define MSS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mss assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define MSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mss assertion failed");

`else

`define MSS_ASSERT(lbl, clk, rst_n, prop)
`define MSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/mss_pkg.sv =====
// shared types and constants for the multi-stack shared store
// no dependencies
`default_nettype none

package mss_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int STACKS_DEF  = 4;
    localparam int DATA_W      = 32;
    localparam int SEL_W       = 2;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_valid;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hw/rtl/mss_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module mss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/mss_ctrl.sv =====
// controller state machine: input handshake and sequencing of one operation
// depends on mss_pkg and multi_stack_shared_store_assert.svh
`default_nettype none

`include "multi_stack_shared_store_assert.svh"

module mss_ctrl
    import mss_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_out_stall,
    input  wire t_dp_status i_status,
    output t_ctrl_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   can_finish;

    // result register is free, or its transaction completes this cycle
    assign can_finish = !i_status.out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (can_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = 1'b1;
        o_cmd.accept = 1'b0;
        o_cmd.exec   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = can_finish;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    `MSS_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, o_cmd.accept, r_state == ST_EXEC)
    `MSS_ASSERT(a_exec_not_with_accept, i_clk, i_rst_n, !(o_cmd.exec && o_cmd.accept))

endmodule

`default_nettype wire

// ===== hw/rtl/mss_dp.sv =====
// datapath: stack tops, free list head, data and link rams, result register
// depends on mss_pkg, mss_ram and multi_stack_shared_store_assert.svh
`default_nettype none

`include "multi_stack_shared_store_assert.svh"

module mss_dp
    import mss_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int STACKS  = STACKS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_ctrl_cmd                 i_cmd,
    output t_dp_status                     o_status,
    input  wire logic                      i_opcode,
    input  wire logic [SEL_W-1:0]          i_stack_sel,
    input  wire logic signed [DATA_W-1:0]  i_push_value,
    input  wire logic                      i_out_stall,
    output logic                           o_out_valid,
    output logic [STATUS_W-1:0]            o_status_code,
    output logic signed [DATA_W-1:0]       o_pop_value
);

    localparam int PW   = $clog2(ENTRIES + 1);
    localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SELW = (STACKS > 1) ? $clog2(STACKS) : 1;
    localparam logic [PW-1:0] NIL = PW'(ENTRIES);

    // stack tops and free chain head
    logic [PW-1:0]   r_tops [STACKS];
    logic [PW-1:0]   r_free_head;
    // entries at and above this index were never allocated; their link is index + 1
    logic [PW-1:0]   r_fresh;

    // operation in flight
    logic            r_op;
    logic [SELW-1:0] r_sel_idx;
    logic [DATA_W-1:0] r_val;
    logic            r_ok;
    logic [PW-1:0]   r_slot;

    logic            r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [DATA_W-1:0]   r_out_value;

    logic            sel_in_range;
    logic [SELW-1:0] sel_idx;
    logic [PW-1:0]   top_now;
    logic [PW-1:0]   slot_now;
    logic            ok_now;

    logic [PW-1:0]   link_rd;
    logic [DATA_W-1:0] data_rd;
    logic            link_we;
    logic [PW-1:0]   link_wdata;
    logic            data_we;
    logic [PW-1:0]   next_free;

    assign sel_in_range = 32'(i_stack_sel) < 32'(STACKS);
    assign sel_idx      = SELW'(i_stack_sel);
    assign top_now      = sel_in_range ? r_tops[sel_idx] : NIL;
    assign slot_now     = (i_opcode == OP_PUSH) ? r_free_head : top_now;
    assign ok_now       = sel_in_range && (slot_now != NIL);

    // capture the operation and its outcome at accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_opcode;
            r_sel_idx <= sel_idx;
            r_val     <= i_push_value;
            r_ok      <= ok_now;
            r_slot    <= slot_now;
        end
    end

    mss_ram #(
        .WIDTH(PW),
        .DEPTH(ENTRIES)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(r_slot[AW-1:0]),
        .i_wdata(link_wdata),
        .i_re   (i_cmd.accept),
        .i_raddr(slot_now[AW-1:0]),
        .o_rdata(link_rd)
    );

    mss_ram #(
        .WIDTH(DATA_W),
        .DEPTH(ENTRIES)
    ) u_data_ram (
        .i_clk  (i_clk),
        .i_we   (data_we),
        .i_waddr(r_slot[AW-1:0]),
        .i_wdata(r_val),
        .i_re   (i_cmd.accept),
        .i_raddr(slot_now[AW-1:0]),
        .o_rdata(data_rd)
    );

    assign link_we    = i_cmd.exec && r_ok;
    assign data_we    = i_cmd.exec && r_ok && (r_op == OP_PUSH);
    assign link_wdata = (r_op == OP_PUSH) ? r_tops[r_sel_idx] : r_free_head;
    assign next_free  = (r_slot == r_fresh) ? r_slot + PW'(1) : link_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STACKS; i++) begin
                r_tops[i] <= NIL;
            end
            r_free_head <= '0;
            r_fresh     <= '0;
        end else if (i_cmd.exec && r_ok) begin
            if (r_op == OP_PUSH) begin
                r_tops[r_sel_idx] <= r_slot;
                r_free_head       <= next_free;
                if (r_slot == r_fresh) begin
                    r_fresh <= r_fresh + PW'(1);
                end
            end else begin
                r_tops[r_sel_idx] <= link_rd;
                r_free_head       <= r_slot;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            priority if (r_op == OP_PUSH) begin
                r_out_status <= r_ok ? STATUS_DONE : STATUS_FULL;
                r_out_value  <= '0;
            end else if (r_ok) begin
                r_out_status <= STATUS_DONE;
                r_out_value  <= data_rd;
            end else begin
                r_out_status <= STATUS_EMPTY;
                r_out_value  <= '1;
            end
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_out_valid        = r_out_valid;
    assign o_status_code      = r_out_status;
    assign o_pop_value        = r_out_value;

    `MSS_ASSERT(a_free_head_bound, i_clk, i_rst_n, r_free_head <= NIL)
    `MSS_ASSERT(a_fresh_bound, i_clk, i_rst_n, r_fresh <= NIL)
    `MSS_ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n, i_cmd.exec, r_out_valid)

endmodule

`default_nettype wire

// ===== hw/rtl/multi_stack_shared_store.sv =====
// operation: the idle state takes a transaction and reads the top or free head entry from the link
// and data rams; the exec state, once the output register is empty or its result is taken, writes
// them back and loads the result; a new transaction is taken only after the exec state of the last one
// ends, and the next transaction is taken while a result still waits on a stalled output
// reset (synchronous, active low): all stacks empty, free chain from entry zero
// depends on mss_pkg, mss_ctrl, mss_dp and mss_ram
`default_nettype none

module multi_stack_shared_store
    import mss_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int STACKS  = STACKS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_opcode,
    input  wire logic [SEL_W-1:0]          i_stack_sel,
    input  wire logic signed [DATA_W-1:0]  i_push_value,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [STATUS_W-1:0]            o_status,
    output logic signed [DATA_W-1:0]       o_pop_value
);

    t_ctrl_cmd  cmd;
    t_dp_status dp_status;

    mss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_stall(i_out_stall),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    mss_dp #(
        .ENTRIES(ENTRIES),
        .STACKS (STACKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (dp_status),
        .i_opcode     (i_opcode),
        .i_stack_sel  (i_stack_sel),
        .i_push_value (i_push_value),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_status_code(o_status),
        .o_pop_value  (o_pop_value)
    );

endmodule

`default_nettype wire
